// ----- hw/rtl/hrbd_pkg.sv -----
// Shared types, constants and match helpers for the HTTP response body deframer.
package hrbd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  // Depth of the queues between front and back and at the result side.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Header matchers.
  localparam int LEN_N = 14;
  localparam int TE_N  = 17;
  localparam int CH_N  = 7;
  localparam logic [8*LEN_N-1:0] PAT_LEN = "content-length";
  localparam logic [8*TE_N-1:0]  PAT_TE  = "transfer-encoding";
  localparam logic [8*CH_N-1:0]  PAT_CH  = "chunked";

  // Length matcher positions past a full match.
  localparam logic [3:0] SEEK_DIGITS = 4'(LEN_N);
  localparam logic [3:0] RUN_TAKEN   = 4'(LEN_N + 1);

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // Status codes.
  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_HDR_OPEN  = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd3;
  localparam logic [2:0] ST_BAD_CRLF  = 3'd4;
  localparam logic [2:0] ST_EMPTY_CHK = 3'd5;

  // Line flag bit positions.
  localparam int FL_LEN = 0;
  localparam int FL_TE  = 1;
  localparam int FL_CH  = 2;
  localparam int FL_RUN = 3;

  // One byte as classified by the front part.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic       closed;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] hex_val;
  } cls_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic [2:0] status;
  } res_item_t;

  function automatic logic [3:0] adv_len(logic [3:0] pos, logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < LEN_N) ch = PAT_LEN[(LEN_N - 1 - int'(pos)) * 8 +: 8];
    if (int'(pos) < LEN_N && c == ch) return pos + 4'd1;
    return (c == PAT_LEN[8*LEN_N-1 -: 8]) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic [4:0] adv_te(logic [4:0] pos, logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < TE_N) ch = PAT_TE[(TE_N - 1 - int'(pos)) * 8 +: 8];
    if (int'(pos) < TE_N && c == ch) return pos + 5'd1;
    return (c == PAT_TE[8*TE_N-1 -: 8]) ? 5'd1 : 5'd0;
  endfunction

  function automatic logic [2:0] adv_ch(logic [2:0] pos, logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < CH_N) ch = PAT_CH[(CH_N - 1 - int'(pos)) * 8 +: 8];
    if (int'(pos) < CH_N && c == ch) return pos + 3'd1;
    return (c == PAT_CH[8*CH_N-1 -: 8]) ? 3'd1 : 3'd0;
  endfunction

endpackage

// ----- hw/rtl/hrbd_fifo.sv -----
// Two-entry queue of registered items, used between front and back and at the result side.
module hrbd_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  item_t                      mem_r [hrbd_pkg::QDEPTH];
  logic [hrbd_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [hrbd_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [hrbd_pkg::QPTR_W:0]   count_r;
  logic                        do_wr;
  logic                        do_rd;

  assign full    = (count_r == (hrbd_pkg::QPTR_W+1)'(hrbd_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hrbd_front.sv -----
// Front part: classify each received byte (case fold, CR/LF, decimal and hex digits).
module hrbd_front (
  input  logic [7:0]          byte_val,
  input  logic                closed,
  output hrbd_pkg::cls_item_t item
);

  logic upper;
  logic dig;
  logic hex_lo;
  logic hex_up;

  assign upper  = (byte_val >= 8'h41) && (byte_val <= 8'h5a);
  assign dig    = (byte_val >= 8'h30) && (byte_val <= 8'h39);
  assign hex_lo = (byte_val >= 8'h61) && (byte_val <= 8'h66);
  assign hex_up = (byte_val >= 8'h41) && (byte_val <= 8'h46);

  always_comb begin
    item.raw      = byte_val;
    item.lower    = upper ? (byte_val + 8'h20) : byte_val;
    item.closed   = closed;
    item.is_cr    = (byte_val == hrbd_pkg::CHAR_CR);
    item.is_lf    = (byte_val == hrbd_pkg::CHAR_LF);
    item.is_digit = dig;
    item.is_hex   = dig || hex_lo || hex_up;
    item.hex_val  = dig ? byte_val[3:0] : (byte_val[3:0] + 4'd9);
  end

endmodule

// ----- hw/rtl/hrbd_back.sv -----
// Back part: header parsing, body framing and status for classified bytes.
module hrbd_back #(
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_avail,
  input  hrbd_pkg::cls_item_t item,
  output logic                item_take,
  input  logic                res_full,
  output logic                res_push,
  output hrbd_pkg::res_item_t res
);

  typedef enum logic [7:0] {
    PH_HEADER      = 8'b0000_0001,
    PH_HEADER_ZERO = 8'b0000_0010,
    PH_FIXED       = 8'b0000_0100,
    PH_CSIZE       = 8'b0000_1000,
    PH_CLF         = 8'b0001_0000,
    PH_CDATA       = 8'b0010_0000,
    PH_RAW         = 8'b0100_0000,
    PH_STOP        = 8'b1000_0000
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_LIM  = LEN_MASK - 1'b1;

  phase_t                 phase_r,    phase_nxt;
  logic [2:0]             nl_run_r,   nl_run_nxt;
  logic [3:0]             len_pos_r,  len_pos_nxt;
  logic [4:0]             te_pos_r,   te_pos_nxt;
  logic [2:0]             ch_pos_r,   ch_pos_nxt;
  logic [3:0]             flags_r,    flags_nxt;
  logic [LENGTH_BITS-1:0] clen_r,     clen_nxt;
  logic                   chunked_r,  chunked_nxt;
  logic [LENGTH_BITS-1:0] rem_r,      rem_nxt;
  logic                   seen_r,     seen_nxt;
  logic                   nonzero_r,  nonzero_nxt;
  logic [2:0]             stop_r,     stop_nxt;

  logic                   fire;
  logic [LENGTH_BITS+3:0] dec_acc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [2:0]             code;
  logic                   do_stop;

  assign fire      = item_avail && !res_full;
  assign item_take = fire;
  assign res_push  = fire;

  // cl*10 + digit, widened so the saturation compare sees the carry
  assign dec_acc = ({4'b0, clen_r} << 3) + ({4'b0, clen_r} << 1)
                 + (LENGTH_BITS+4)'(item.raw[3:0]);
  assign rem_dec = rem_r - 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    nl_run_nxt  = nl_run_r;
    len_pos_nxt = len_pos_r;
    te_pos_nxt  = te_pos_r;
    ch_pos_nxt  = ch_pos_r;
    flags_nxt   = flags_r;
    clen_nxt    = clen_r;
    chunked_nxt = chunked_r;
    rem_nxt     = rem_r;
    seen_nxt    = seen_r;
    nonzero_nxt = nonzero_r;
    stop_nxt    = stop_r;
    res.body_byte  = 8'h00;
    res.body_valid = 1'b0;
    res.status     = hrbd_pkg::ST_RUNNING;
    code    = hrbd_pkg::ST_RUNNING;
    do_stop = 1'b0;

    if (phase_r == PH_STOP) begin
      res.status = stop_r;
    end else if (item.closed) begin
      do_stop = 1'b1;
      unique case (phase_r) inside
        PH_HEADER, PH_HEADER_ZERO: code = hrbd_pkg::ST_HDR_OPEN;
        PH_CLF:                    code = hrbd_pkg::ST_BAD_CRLF;
        PH_CSIZE, PH_CDATA:
          code = nonzero_r ? hrbd_pkg::ST_DONE : hrbd_pkg::ST_EMPTY_CHK;
        default:                   code = hrbd_pkg::ST_DONE;
      endcase
    end else begin
      unique case (phase_r) inside
        PH_HEADER, PH_HEADER_ZERO: begin
          nl_run_nxt = (item.is_cr || item.is_lf) ? (nl_run_r + 3'd1) : 3'd0;
          if (phase_r == PH_HEADER && !item.is_lf) begin
            if (!flags_r[hrbd_pkg::FL_LEN]) begin
              len_pos_nxt = hrbd_pkg::adv_len(len_pos_r, item.lower);
              if (len_pos_nxt == hrbd_pkg::SEEK_DIGITS) flags_nxt[hrbd_pkg::FL_LEN] = 1'b1;
            end else if (len_pos_r == hrbd_pkg::SEEK_DIGITS) begin
              if (item.is_digit) begin
                clen_nxt = LENGTH_BITS'(item.raw[3:0]);
                flags_nxt[hrbd_pkg::FL_RUN] = 1'b1;
                len_pos_nxt = hrbd_pkg::RUN_TAKEN;
              end
            end else if (flags_r[hrbd_pkg::FL_RUN]) begin
              if (item.is_digit) begin
                clen_nxt = (dec_acc > (LENGTH_BITS+4)'(LEN_LIM)) ? LEN_LIM
                                                               : dec_acc[LENGTH_BITS-1:0];
              end else begin
                // digit run over: a zero length parks the header
                flags_nxt[hrbd_pkg::FL_RUN] = 1'b0;
                if (clen_r == '0) phase_nxt = PH_HEADER_ZERO;
              end
            end
            if (!flags_r[hrbd_pkg::FL_TE]) begin
              te_pos_nxt = hrbd_pkg::adv_te(te_pos_r, item.lower);
              if (te_pos_nxt == 5'(hrbd_pkg::TE_N)) flags_nxt[hrbd_pkg::FL_TE] = 1'b1;
            end
            if (!flags_r[hrbd_pkg::FL_CH]) begin
              ch_pos_nxt = hrbd_pkg::adv_ch(ch_pos_r, item.lower);
              if (ch_pos_nxt == 3'(hrbd_pkg::CH_N)) flags_nxt[hrbd_pkg::FL_CH] = 1'b1;
            end
          end
          // end of header line
          if (phase_nxt == PH_HEADER && (item.is_lf || nl_run_nxt >= 3'd4)) begin
            if (flags_nxt[hrbd_pkg::FL_RUN] && clen_nxt == '0) phase_nxt = PH_HEADER_ZERO;
            if (!flags_nxt[hrbd_pkg::FL_LEN] && flags_nxt[hrbd_pkg::FL_TE]
                && flags_nxt[hrbd_pkg::FL_CH]) chunked_nxt = 1'b1;
            flags_nxt   = '0;
            len_pos_nxt = '0;
            te_pos_nxt  = '0;
            ch_pos_nxt  = '0;
          end
          // end of header
          if (nl_run_nxt >= 3'd4) begin
            nl_run_nxt = 3'd0;
            if (phase_nxt == PH_HEADER_ZERO) begin
              do_stop = 1'b1;
              code    = hrbd_pkg::ST_ZERO_LEN;
            end else if (clen_nxt != LEN_MASK && clen_nxt != '0) begin
              phase_nxt = PH_FIXED;
              rem_nxt   = clen_nxt;
            end else if (chunked_nxt) begin
              phase_nxt = PH_CSIZE;
              rem_nxt   = '0;
              seen_nxt  = 1'b0;
            end else begin
              phase_nxt = PH_RAW;
            end
          end
        end
        PH_FIXED: begin
          if (rem_r == '0) begin
            do_stop = 1'b1;
            code    = hrbd_pkg::ST_DONE;
          end else begin
            res.body_byte  = item.raw;
            res.body_valid = 1'b1;
            rem_nxt        = rem_dec;
            if (rem_dec == '0) begin
              do_stop = 1'b1;
              code    = hrbd_pkg::ST_DONE;
            end
          end
        end
        PH_CSIZE: begin
          if (item.is_hex) begin
            rem_nxt  = (rem_r[LENGTH_BITS-1 -: 4] != 4'd0) ? LEN_MASK
                                                           : {rem_r[LENGTH_BITS-5:0], item.hex_val};
            seen_nxt = 1'b1;
          end else if (seen_r) begin
            if (rem_r == '0) begin
              do_stop = 1'b1;
              code    = nonzero_r ? hrbd_pkg::ST_DONE : hrbd_pkg::ST_EMPTY_CHK;
            end else if (!item.is_cr) begin
              do_stop = 1'b1;
              code    = hrbd_pkg::ST_BAD_CRLF;
            end else begin
              phase_nxt = PH_CLF;
            end
          end
        end
        PH_CLF: begin
          if (!item.is_lf) begin
            do_stop = 1'b1;
            code    = hrbd_pkg::ST_BAD_CRLF;
          end else begin
            phase_nxt = PH_CDATA;
          end
        end
        PH_CDATA: begin
          res.body_byte  = item.raw;
          res.body_valid = 1'b1;
          nonzero_nxt    = 1'b1;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_CSIZE;
            seen_nxt  = 1'b0;
          end
        end
        PH_RAW: begin
          res.body_byte  = item.raw;
          res.body_valid = 1'b1;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    if (do_stop) begin
      phase_nxt  = PH_STOP;
      stop_nxt   = code;
      res.status = code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      nl_run_r  <= '0;
      len_pos_r <= '0;
      te_pos_r  <= '0;
      ch_pos_r  <= '0;
      flags_r   <= '0;
      clen_r    <= LEN_MASK;
      chunked_r <= 1'b0;
      rem_r     <= '0;
      seen_r    <= 1'b0;
      nonzero_r <= 1'b0;
      stop_r    <= hrbd_pkg::ST_RUNNING;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      nl_run_r  <= nl_run_nxt;
      len_pos_r <= len_pos_nxt;
      te_pos_r  <= te_pos_nxt;
      ch_pos_r  <= ch_pos_nxt;
      flags_r   <= flags_nxt;
      clen_r    <= clen_nxt;
      chunked_r <= chunked_nxt;
      rem_r     <= rem_nxt;
      seen_r    <= seen_nxt;
      nonzero_r <= nonzero_nxt;
      stop_r    <= stop_nxt;
    end
  end

endmodule

// ----- hw/rtl/http_response_body_deframer.sv -----
// Top level of the HTTP response body deframer: front classifier, queue, back parser, result queue.
//
// Feed response bytes with push while full is low; assert in_closed (byte ignored) when the
// connection closes. Every transfer in yields exactly one result: out_body_valid marks a
// body byte on out_body_byte (zero otherwise) and out_status gives 0 while running, then
// 1 done, 2 header unfinished, 3 zero content length, 4 bad chunk CR/LF, 5 empty chunked
// body; once a final status appears it repeats for every later byte. The header ends on the
// fourth consecutive CR or LF; a "content-length" line selects a counted body, a
// "transfer-encoding" line naming "chunked" selects chunked framing, else every byte passes
// until close. Lengths saturate at LENGTH_BITS. Throughput is one byte per clock while bytes wait
// and the result queue has room: the back parser settles each byte combinationally from its state
// registers. A byte is written into the classifier queue, taken by the parser into the result
// queue, then shown on the output ports; a two-entry queue sits between classifier and parser
// and another at the result side, so either side can stall without stopping the other.
module http_response_body_deframer #(
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_closed,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_body_byte,
  output logic       out_body_valid,
  output logic [2:0] out_status
);

  hrbd_pkg::cls_item_t cls_in;
  hrbd_pkg::cls_item_t cls_out;
  hrbd_pkg::res_item_t res_in;
  hrbd_pkg::res_item_t res_out;
  logic                cls_empty;
  logic                cls_take;
  logic                res_full;
  logic                res_push;

  // Classify the incoming byte before it enters the queue.
  hrbd_front u_front (
    .byte_val (in_byte),
    .closed   (in_closed),
    .item     (cls_in)
  );

  // Hold classified bytes until the parser takes them.
  hrbd_fifo #(
    .item_t (hrbd_pkg::cls_item_t)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (cls_in),
    .rd_en   (cls_take),
    .rd_item (cls_out),
    .full    (full),
    .empty   (cls_empty)
  );

  // Advance the parser one byte whenever a classified byte waits and a result slot is free.
  hrbd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_avail (!cls_empty),
    .item       (cls_out),
    .item_take  (cls_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  // Hold results until the consumer pops them.
  hrbd_fifo #(
    .item_t (hrbd_pkg::res_item_t)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_item (res_in),
    .rd_en   (pop),
    .rd_item (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_body_byte  = res_out.body_byte;
  assign out_body_valid = res_out.body_valid;
  assign out_status     = res_out.status;

endmodule
